>>> rtl/fsa_pkg.sv
`timescale 1ns / 1ps

package fsa_pkg;

  // Grid size
  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;

  // Field widths
  localparam int ROW_W     = 5;
  localparam int COL_W     = 5;
  localparam int FREE_W    = 10;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int TAG_LO_W  = 64;
  localparam int TAG_HI_W  = 16;

  // Command codes
  localparam logic CMD_PARK  = 1'b0;
  localparam logic CMD_LEAVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ALLOC     = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RELEASED  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // Force a written size into 1..maxv
  function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int maxv);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (int'(v) > maxv) begin
      res = CFG_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  localparam logic [CFG_W-1:0] RST_ROWS = clamp_size(CFG_W'(16), MAX_ROWS);
  localparam logic [CFG_W-1:0] RST_COLS = clamp_size(CFG_W'(16), MAX_COLS);

  typedef struct packed {
    logic                cmd;
    logic [TAG_LO_W-1:0] tag_low;
    logic [TAG_HI_W-1:0] tag_high;
  } fsa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ROW_W-1:0]  slot_row;
    logic [COL_W-1:0]  slot_col;
    logic [FREE_W-1:0] free_left;
  } fsa_out_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                park_go;
    logic                leave_go;
    logic                init_en;
    logic [CFG_W-1:0]    init_cols;
    logic [CFG_W-1:0]    rows;
    logic [CFG_W-1:0]    cols;
    logic                rel_en;
    logic [ROW_W-1:0]    rel_row;
    logic [COL_W-1:0]    rel_col;
    logic [FREE_W-1:0]   rel_rank;
    logic [TAG_LO_W-1:0] tag_low;
    logic [TAG_HI_W-1:0] tag_high;
  } fsa_ctl_t;

  typedef enum logic [1:0] {
    FSA_IDLE,
    FSA_SCAN,
    FSA_PICK
  } fsa_state_t;

endpackage

>>> rtl/fifo_slot_allocator_with_tag_release_top.sv
`timescale 1ns / 1ps

// Slot allocator over a grid of up to 16 x 16 slots with release by tag.
// Input channel: a request transfers at a clock edge with start high and busy
// low. in_item.cmd selects park (allocate the lowest-ranked free slot and
// store the 80-bit tag) or leave (free the first occupied slot, row-major,
// whose tag matches).
// Result channel: out_valid is high for exactly one cycle with out_item
// holding status, slot row/column and the free count after the request. The
// receiver takes it in that cycle; there is no back-pressure.
// Timing: after the accepting edge the cells update ranks and compare tags,
// then the priority chain along each row is registered, then the pick across
// rows is registered into the result. busy stays high until the result is
// shown, so a new request is taken only after the last one is through.
// Configuration: cfg_we with cfg_idx 0 (rows) or 1 (columns) writes a size,
// clamped to 1..16, and re-initializes the grid in the same edge: all slots
// in use become free with ranks in row-major order. Other indexes are ignored.
// Reset: 16 x 16 in use, all slots free, free count 256.

module fifo_slot_allocator_with_tag_release_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  fsa_pkg::fsa_in_t               in_item,
  output logic                           out_valid,
  output fsa_pkg::fsa_out_t              out_item,
  input  logic                           cfg_we,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fsa_pkg::CFG_W-1:0]      cfg_wdata
);

  fsa_pkg::fsa_state_t           state_r;
  fsa_pkg::fsa_state_t           state_nxt;
  logic [fsa_pkg::CFG_W-1:0]     rows_r;
  logic [fsa_pkg::CFG_W-1:0]     rows_nxt;
  logic [fsa_pkg::CFG_W-1:0]     cols_r;
  logic [fsa_pkg::CFG_W-1:0]     cols_nxt;
  logic [fsa_pkg::FREE_W-1:0]    free_r;
  logic                          cmd_r;
  logic                          accept;
  logic                          cfg_hit;
  logic                          scan_en;
  logic                          pick_en;
  logic                          found;
  logic [fsa_pkg::ROW_W-1:0]     win_row;
  logic [fsa_pkg::COL_W-1:0]     win_col;
  logic [fsa_pkg::MAX_ROWS-1:0]  row_any;
  logic [fsa_pkg::COL_W-1:0]     row_col [fsa_pkg::MAX_ROWS];
  logic                          release_go;
  fsa_pkg::fsa_ctl_t             ctl;
  fsa_pkg::fsa_out_t             out_nxt;

  assign accept  = start && !busy;
  assign cfg_hit = cfg_we && ((cfg_idx == fsa_pkg::REG_ROWS) ||
                              (cfg_idx == fsa_pkg::REG_COLS));

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsa_pkg::FSA_IDLE: if (accept) state_nxt = fsa_pkg::FSA_SCAN;
      fsa_pkg::FSA_SCAN: state_nxt = fsa_pkg::FSA_PICK;
      fsa_pkg::FSA_PICK: state_nxt = fsa_pkg::FSA_IDLE;
      default:           state_nxt = fsa_pkg::FSA_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    busy    = 1'b0;
    scan_en = 1'b0;
    pick_en = 1'b0;
    unique case (state_r)
      fsa_pkg::FSA_IDLE: busy = 1'b0;
      fsa_pkg::FSA_SCAN: begin
        busy    = 1'b1;
        scan_en = 1'b1;
      end
      fsa_pkg::FSA_PICK: begin
        busy    = 1'b1;
        pick_en = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsa_pkg::FSA_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Size registers, clamped on write
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we && (cfg_idx == fsa_pkg::REG_ROWS)) begin
      rows_nxt = fsa_pkg::clamp_size(cfg_wdata, fsa_pkg::MAX_ROWS);
    end
    if (cfg_we && (cfg_idx == fsa_pkg::REG_COLS)) begin
      cols_nxt = fsa_pkg::clamp_size(cfg_wdata, fsa_pkg::MAX_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= fsa_pkg::RST_ROWS;
      cols_r <= fsa_pkg::RST_COLS;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // Hold the command of the request in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.cmd;
    end
  end

  // Pick the first row with a flagged cell
  always_comb begin
    found   = 1'b0;
    win_row = '0;
    win_col = '0;
    for (int r = 0; r < fsa_pkg::MAX_ROWS; r++) begin
      if (!found && row_any[r]) begin
        found   = 1'b1;
        win_row = fsa_pkg::ROW_W'(r);
        win_col = row_col[r];
      end
    end
  end

  assign release_go = pick_en && (cmd_r == fsa_pkg::CMD_LEAVE) && found;

  // Free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= fsa_pkg::FREE_W'(fsa_pkg::RST_ROWS) * fsa_pkg::FREE_W'(fsa_pkg::RST_COLS);
    end else if (cfg_hit) begin
      free_r <= fsa_pkg::FREE_W'(rows_nxt) * fsa_pkg::FREE_W'(cols_nxt);
    end else if (accept && (in_item.cmd == fsa_pkg::CMD_PARK) && (free_r != '0)) begin
      free_r <= free_r - fsa_pkg::FREE_W'(1);
    end else if (release_go) begin
      free_r <= free_r + fsa_pkg::FREE_W'(1);
    end
  end

  // Broadcast to the cells; a park on a full grid finds no free cell and
  // clears every candidate flag
  always_comb begin
    ctl.park_go   = accept && (in_item.cmd == fsa_pkg::CMD_PARK);
    ctl.leave_go  = accept && (in_item.cmd == fsa_pkg::CMD_LEAVE);
    ctl.init_en   = cfg_hit;
    ctl.init_cols = cols_nxt;
    ctl.rows      = rows_r;
    ctl.cols      = cols_r;
    ctl.rel_en    = release_go;
    ctl.rel_row   = win_row;
    ctl.rel_col   = win_col;
    ctl.rel_rank  = free_r + fsa_pkg::FREE_W'(1);
    ctl.tag_low   = in_item.tag_low;
    ctl.tag_high  = in_item.tag_high;
  end

  // Rows of cells
  for (genvar r = 0; r < fsa_pkg::MAX_ROWS; r++) begin : g_row
    fsa_row u_row (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .row_idx (fsa_pkg::ROW_W'(r)),
      .scan_en (scan_en),
      .any_r   (row_any[r]),
      .col_r   (row_col[r])
    );
  end

  // Form the result
  always_comb begin
    out_nxt.slot_row  = found ? win_row : '0;
    out_nxt.slot_col  = found ? win_col : '0;
    out_nxt.free_left = release_go ? (free_r + fsa_pkg::FREE_W'(1)) : free_r;
    if (cmd_r == fsa_pkg::CMD_PARK) begin
      out_nxt.status = found ? fsa_pkg::ST_ALLOC : fsa_pkg::ST_FULL;
    end else begin
      out_nxt.status = found ? fsa_pkg::ST_RELEASED : fsa_pkg::ST_NOT_FOUND;
    end
  end

  // Output register: one-cycle strobe per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pick_en;
    end
  end

  always_ff @(posedge clk) begin
    if (pick_en) begin
      out_item <= out_nxt;
    end
  end

endmodule

>>> rtl/fsa_cell.sv
`timescale 1ns / 1ps

module fsa_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fsa_pkg::fsa_ctl_t          ctl,
  input  logic [fsa_pkg::ROW_W-1:0]  cell_row,
  input  logic [fsa_pkg::COL_W-1:0]  cell_col,
  input  logic                       seen_in,
  output logic                       seen_out,
  output logic                       first
);

  logic                          taken_r;
  logic [fsa_pkg::FREE_W-1:0]    rank_r;
  logic                          sel_r;
  logic [fsa_pkg::TAG_LO_W-1:0]  tag_low_r;
  logic [fsa_pkg::TAG_HI_W-1:0]  tag_high_r;
  logic                          in_use;
  logic                          take;
  logic                          tag_hit;
  logic                          rel_hit;
  logic [fsa_pkg::FREE_W-1:0]    rank_base;

  assign in_use  = (cell_row < fsa_pkg::ROW_W'(ctl.rows)) &&
                   (cell_col < fsa_pkg::COL_W'(ctl.cols));
  assign take    = ctl.park_go && in_use && !taken_r &&
                   (rank_r == fsa_pkg::FREE_W'(1));
  assign tag_hit = (tag_low_r == ctl.tag_low) && (tag_high_r == ctl.tag_high);
  assign rel_hit = ctl.rel_en && (cell_row == ctl.rel_row) && (cell_col == ctl.rel_col);

  // Column position plus one; the row offset is added where the rank is loaded
  assign rank_base = fsa_pkg::FREE_W'(cell_col) + fsa_pkg::FREE_W'(1);

  // Rank and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 1'b0;
      rank_r  <= fsa_pkg::FREE_W'(cell_row) * fsa_pkg::FREE_W'(fsa_pkg::RST_COLS) + rank_base;
    end else if (ctl.init_en) begin
      taken_r <= 1'b0;
      rank_r  <= fsa_pkg::FREE_W'(cell_row) * fsa_pkg::FREE_W'(ctl.init_cols) + rank_base;
    end else if (take) begin
      taken_r <= 1'b1;
    end else if (ctl.park_go && in_use && !taken_r) begin
      rank_r  <= rank_r - fsa_pkg::FREE_W'(1);
    end else if (rel_hit) begin
      taken_r <= 1'b0;
      rank_r  <= ctl.rel_rank;
    end
  end

  // Flag this cell as a candidate for the request just accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (ctl.park_go) begin
      sel_r <= take;
    end else if (ctl.leave_go) begin
      sel_r <= in_use && taken_r && tag_hit;
    end
  end

  // Store the tag of a parked item
  always_ff @(posedge clk) begin
    if (take) begin
      tag_low_r  <= ctl.tag_low;
      tag_high_r <= ctl.tag_high;
    end
  end

  // Hand the found flag to the right neighbor
  assign seen_out = seen_in | sel_r;
  assign first    = sel_r & ~seen_in;

endmodule

>>> rtl/fsa_row.sv
`timescale 1ns / 1ps

module fsa_row (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fsa_pkg::fsa_ctl_t          ctl,
  input  logic [fsa_pkg::ROW_W-1:0]  row_idx,
  input  logic                       scan_en,
  output logic                       any_r,
  output logic [fsa_pkg::COL_W-1:0]  col_r
);

  logic [fsa_pkg::MAX_COLS:0]   seen;
  logic [fsa_pkg::MAX_COLS-1:0] first;
  logic [fsa_pkg::COL_W-1:0]    col_nxt;

  assign seen[0] = 1'b0;

  // Chain of cells along the row
  for (genvar c = 0; c < fsa_pkg::MAX_COLS; c++) begin : g_cell
    fsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cell_row (row_idx),
      .cell_col (fsa_pkg::COL_W'(c)),
      .seen_in  (seen[c]),
      .seen_out (seen[c+1]),
      .first    (first[c])
    );
  end

  // Encode the leftmost flagged column (at most one first bit is set)
  always_comb begin
    col_nxt = '0;
    for (int c = 0; c < fsa_pkg::MAX_COLS; c++) begin
      col_nxt = col_nxt | (first[c] ? fsa_pkg::COL_W'(c) : '0);
    end
  end

  // Register the row summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else if (scan_en) begin
      any_r <= seen[fsa_pkg::MAX_COLS];
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en) begin
      col_r <= col_nxt;
    end
  end

endmodule

>>> test/fifo_slot_allocator_with_tag_release_top_tb.sv
`timescale 1ns / 1ps

module fifo_slot_allocator_with_tag_release_top_tb;
  import fsa_pkg::*;

  localparam logic [10:0] RANK_TAKEN = 11'h7FF;
  localparam int SLOTS = MAX_ROWS * MAX_COLS;
  // Indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  fsa_in_t              in_item = '0;
  logic                 out_valid;
  fsa_out_t             out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  fifo_slot_allocator_with_tag_release_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the grid
  logic [10:0] grid_rank [SLOTS];
  logic [79:0] grid_tag [SLOTS];
  int          rows_used;
  int          cols_used;
  logic [9:0]  free_slots;

  fsa_in_t     request_queue [$];
  fsa_out_t    expected_results [$];
  logic [79:0] parked_tags [$];
  fsa_out_t    want;
  int          fail_count = 0;
  int          burst_left;
  int          gap_left;

  function automatic int fit_size(logic [CFG_W-1:0] v, int maxv);
    int res;
    res = int'(v);
    if (res < 1) res = 1;
    if (res > maxv) res = maxv;
    return res;
  endfunction

  // Free every slot in use, ranks in row-major order
  function automatic void rebuild_grid();
    for (int r = 0; r < rows_used; r++) begin
      for (int c = 0; c < cols_used; c++) begin
        grid_rank[r * MAX_COLS + c] = 11'(r * cols_used + c + 1);
      end
    end
    free_slots = 10'(rows_used * cols_used);
  endfunction

  function automatic void grid_reset();
    rows_used = fit_size(CFG_W'(16), MAX_ROWS);
    cols_used = fit_size(CFG_W'(16), MAX_COLS);
    for (int i = 0; i < SLOTS; i++) begin
      grid_rank[i] = '0;
      grid_tag[i] = '0;
    end
    rebuild_grid();
  endfunction

  function automatic void grid_write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == REG_ROWS) begin
      rows_used = fit_size(data, MAX_ROWS);
      rebuild_grid();
    end else if (idx == REG_COLS) begin
      cols_used = fit_size(data, MAX_COLS);
      rebuild_grid();
    end
  endfunction

  // Work out the result of one request and update the grid copy
  function automatic fsa_out_t slot_grid_step(fsa_in_t req);
    fsa_out_t    res;
    logic [79:0] tag;
    logic        hit;
    int          i;
    res = '0;
    tag = {req.tag_high, req.tag_low};
    hit = 1'b0;
    if (req.cmd == CMD_PARK) begin
      if (free_slots == 0) begin
        res.status = ST_FULL;
      end else begin
        for (int r = 0; r < rows_used; r++) begin
          for (int c = 0; c < cols_used; c++) begin
            i = r * MAX_COLS + c;
            if (grid_rank[i] != RANK_TAKEN && grid_rank[i] != 0) begin
              grid_rank[i] = grid_rank[i] - 1'b1;
              if (grid_rank[i] == 0) begin
                grid_rank[i] = RANK_TAKEN;
                grid_tag[i] = tag;
                res.slot_row = ROW_W'(r);
                res.slot_col = COL_W'(c);
                hit = 1'b1;
              end
            end
          end
        end
        if (hit) begin
          free_slots = free_slots - 1'b1;
          res.status = ST_ALLOC;
        end else begin
          res.status = ST_FULL;
        end
      end
    end else begin
      res.status = ST_NOT_FOUND;
      for (int r = 0; r < rows_used && !hit; r++) begin
        for (int c = 0; c < cols_used && !hit; c++) begin
          i = r * MAX_COLS + c;
          if (grid_rank[i] == RANK_TAKEN && grid_tag[i] == tag) begin
            free_slots = free_slots + 1'b1;
            grid_rank[i] = 11'(free_slots);
            res.slot_row = ROW_W'(r);
            res.slot_col = COL_W'(c);
            res.status = ST_RELEASED;
            hit = 1'b1;
          end
        end
      end
    end
    res.free_left = free_slots;
    return res;
  endfunction

  initial grid_reset();

  // Driver: bursts of requests with random gaps, predict on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(slot_grid_step(in_item));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_item <= request_queue.pop_front();
          start <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = $urandom_range(1) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every strobed result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: status %0d row %0d col %0d free %0d",
               out_item.status, out_item.slot_row, out_item.slot_col, out_item.free_left);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
        if (out_item.slot_row !== want.slot_row) begin
          $error("slot_row: expected %0d, got %0d", want.slot_row, out_item.slot_row);
          fail_count++;
        end
        if (out_item.slot_col !== want.slot_col) begin
          $error("slot_col: expected %0d, got %0d", want.slot_col, out_item.slot_col);
          fail_count++;
        end
        if (out_item.free_left !== want.free_left) begin
          $error("free_left: expected %0d, got %0d", want.free_left, out_item.free_left);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [79:0] random_tag();
    logic [79:0] t;
    int          len;
    t = '0;
    if ($urandom_range(1)) begin
      t[79:64] = 16'($urandom);
      t[63:32] = $urandom;
      t[31:0]  = $urandom;
    end else begin
      // zero-padded text tag
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) t[k * 8 +: 8] = 8'($urandom_range(33, 126));
    end
    return t;
  endfunction

  function automatic void queue_request(logic cmd, logic [79:0] t);
    fsa_in_t req;
    req.cmd = cmd;
    req.tag_low = t[63:0];
    req.tag_high = t[79:64];
    request_queue.push_back(req);
    if (cmd == CMD_PARK) parked_tags.push_back(t);
  endfunction

  // Mostly parks and leaves of parked tags, some unknown or near-miss tags
  function automatic void queue_phase(int count, int park_pct);
    logic [79:0] t;
    int          k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < park_pct) begin
        if (parked_tags.size() > 0 && $urandom_range(9) == 0) begin
          t = parked_tags[$urandom_range(parked_tags.size() - 1)];
        end else begin
          t = random_tag();
        end
        queue_request(CMD_PARK, t);
      end else if (parked_tags.size() > 0 && $urandom_range(99) < 80) begin
        k = $urandom_range(parked_tags.size() - 1);
        t = parked_tags[k];
        parked_tags.delete(k);
        queue_request(CMD_LEAVE, t);
      end else if (parked_tags.size() > 0 && $urandom_range(1)) begin
        t = parked_tags[$urandom_range(parked_tags.size() - 1)];
        t = t ^ (80'd1 << $urandom_range(79));
        queue_request(CMD_LEAVE, t);
      end else begin
        queue_request(CMD_LEAVE, random_tag());
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    grid_write_size(idx, data);
  endtask

  task automatic set_grid(logic [CFG_W-1:0] nrows, logic [CFG_W-1:0] ncols);
    write_reg(REG_ROWS, nrows);
    write_reg(REG_COLS, ncols);
    @(posedge clk);
    cfg_we <= 1'b0;
    parked_tags.delete();
  endtask

  // Drain all requests, allow the results to arrive, then let the block settle
  task automatic wait_idle();
    int k;
    while (request_queue.size() != 0 || start) @(posedge clk);
    for (k = 0; k < 200 && expected_results.size() != 0; k++) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
      expected_results.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [79:0] tag_ab;
    logic [79:0] tag_full;
    tag_ab = 80'h4241;
    tag_full = 80'h4a49_4847_4645_4443_4241;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed on the reset grid: extreme tags, duplicates, misses
    queue_request(CMD_PARK, '0);
    queue_request(CMD_PARK, '1);
    queue_request(CMD_PARK, tag_ab);
    queue_request(CMD_PARK, tag_ab);
    queue_request(CMD_LEAVE, tag_ab);
    queue_request(CMD_LEAVE, tag_ab);
    queue_request(CMD_LEAVE, tag_ab);
    queue_request(CMD_LEAVE, '1);
    queue_request(CMD_LEAVE, 80'd1 << 79);
    queue_request(CMD_LEAVE, '0);
    queue_request(CMD_PARK, tag_full);
    queue_request(CMD_LEAVE, tag_full);
    wait_idle();

    // Directed on a single slot: full, discarded tag, refill
    set_grid(CFG_W'(1), CFG_W'(1));
    queue_request(CMD_PARK, tag_ab);
    queue_request(CMD_PARK, tag_full);
    queue_request(CMD_LEAVE, tag_full);
    queue_request(CMD_LEAVE, tag_ab);
    queue_request(CMD_PARK, tag_full);
    wait_idle();

    // Zero sizes clamp to one; unknown indexes are ignored
    set_grid(CFG_W'(0), CFG_W'(0));
    write_reg(REG_SPARE_A, CFG_W'(5));
    write_reg(REG_SPARE_B, CFG_W'(31));
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_phase(60, 50);
    wait_idle();

    // Oversize clamps to the full grid; fill it, then drain it
    set_grid('1, '1);
    queue_phase(330, 90);
    wait_idle();
    queue_phase(200, 30);
    wait_idle();

    set_grid(CFG_W'(16), CFG_W'(1));
    queue_phase(150, 65);
    wait_idle();

    set_grid(CFG_W'(1), CFG_W'(16));
    queue_phase(150, 65);
    wait_idle();

    set_grid(CFG_W'(2), CFG_W'(3));
    queue_phase(150, 60);
    wait_idle();

    repeat (5) begin
      write_reg(CFG_IDX_W'($urandom_range(3)), CFG_W'($urandom));
      set_grid(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)));
      queue_phase(160, $urandom_range(40, 80));
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> fifo_slot_allocator_with_tag_release_top.f
rtl/fsa_pkg.sv
rtl/fsa_cell.sv
rtl/fsa_row.sv
rtl/fifo_slot_allocator_with_tag_release_top.sv
test/fifo_slot_allocator_with_tag_release_top_tb.sv
